// ----- rtl/core/tie_pkg.sv -----
// shared types and codes of the execute unit
package tie_pkg;

    localparam int ImmWidth = 32;

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_MOVE = 4'd4;
    localparam logic [3:0] CMD_CMP  = 4'd5;
    localparam logic [3:0] CMD_GCD  = 4'd6;
    localparam logic [3:0] CMD_JUMP = 4'd7;
    localparam logic [3:0] CMD_BEQ  = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_OP   = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO = 3'd2;
    localparam logic [2:0] ST_GCD_ARG  = 3'd3;
    localparam logic [2:0] ST_MOVE_IMM = 3'd4;

    // one classified instruction waiting in the queue
    typedef struct packed {
        logic [3:0]                 cmd;
        logic                       a_from_reg;
        logic [3:0]                 a_reg;
        logic signed [ImmWidth-1:0] a_imm;
        logic                       b_from_reg;
        logic [3:0]                 b_reg;
        logic signed [ImmWidth-1:0] b_imm;
        logic [2:0]                 err;
    } t_entry;

endpackage

// ----- rtl/core/tie_ifs.sv -----
// instruction and result channel interfaces
interface tie_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         cmd;
    logic               a_from_reg;
    logic [3:0]         a_reg;
    logic signed [31:0] a_imm;
    logic               b_from_reg;
    logic [3:0]         b_reg;
    logic signed [31:0] b_imm;

    modport source (output valid, cmd, a_from_reg, a_reg, a_imm, b_from_reg, b_reg, b_imm,
                    input ready);
    modport sink (input valid, cmd, a_from_reg, a_reg, a_imm, b_from_reg, b_reg, b_imm,
                  output ready);
endinterface

interface tie_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] acc_value;
    logic [3:0]         written_reg;
    logic               wrote;
    logic               jump_taken;
    logic signed [31:0] jump_target;
    logic [2:0]         status;

    modport source (output valid, acc_value, written_reg, wrote, jump_taken, jump_target,
                    status, input ready);
    modport sink (input valid, acc_value, written_reg, wrote, jump_taken, jump_target,
                  status, output ready);
endinterface

// ----- rtl/core/tie_front.sv -----
// front end: accepts instructions, flags static errors, two-entry queue
module tie_front
    import tie_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    tie_cmd_if.sink i_cmd_if,
    output logic   o_q_valid,
    output t_entry o_q_entry,
    input  logic   i_q_pop
);

    t_entry     r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_entry     w_in;
    logic       w_push;

    always_comb begin
        w_in.cmd        = i_cmd_if.cmd;
        w_in.a_from_reg = i_cmd_if.a_from_reg;
        w_in.a_reg      = i_cmd_if.a_reg;
        w_in.a_imm      = i_cmd_if.a_imm;
        w_in.b_from_reg = i_cmd_if.b_from_reg;
        w_in.b_reg      = i_cmd_if.b_reg;
        w_in.b_imm      = i_cmd_if.b_imm;
        if (i_cmd_if.cmd > CMD_BEQ) begin
            w_in.err = ST_BAD_OP;
        end else if (i_cmd_if.cmd == CMD_MOVE && !i_cmd_if.a_from_reg) begin
            w_in.err = ST_MOVE_IMM;
        end else begin
            w_in.err = ST_OK;
        end
    end

    // no transaction is taken while reset is held
    assign i_cmd_if.ready = i_rst_n && (r_cnt != 2'd2);
    assign w_push         = i_cmd_if.valid && i_cmd_if.ready;
    assign o_q_valid      = (r_cnt != 2'd0);
    assign o_q_entry      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

// ----- rtl/core/tie_back.sv -----
// back end: register file, iterative multiply, divide and gcd, result register
module tie_back
    import tie_pkg::*;
#(
    parameter int REG_COUNT  = 10,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_entry    i_q_entry,
    output logic      o_q_pop,
    tie_res_if.source o_res_if
);

    localparam int IW = $clog2(REG_COUNT);
    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [DATA_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_vld;
    logic [DATA_WIDTH-1:0] r_acc;

    logic [2:0]            r_st;
    t_entry                r_e;
    logic [DATA_WIDTH-1:0] r_rda, r_rdb;
    logic                  r_a_ok, r_b_ok;
    logic [DATA_WIDTH-1:0] r_x, r_y, r_rem, r_res;
    logic [CW-1:0]         r_cnt;
    logic                  r_neg;
    logic                  r_wr_en;
    logic [3:0]            r_wr_idx;
    logic                  r_taken;
    logic [31:0]           r_target;
    logic [2:0]            r_status;

    logic                  r_ov;
    logic [31:0]           r_o_acc, r_o_tgt;
    logic [3:0]            r_o_idx;
    logic                  r_o_wrote, r_o_taken;
    logic [2:0]            r_o_status;

    logic [DATA_WIDTH-1:0] w_a, w_b, w_ma, w_mb, w_a_imm;
    logic [DATA_WIDTH:0]   w_rem2;
    logic                  w_ge, w_fin_go;
    logic                  w_a_in, w_b_in, w_mv_in;
    logic [DATA_WIDTH-1:0] w_qd;

    function automatic logic in_range(input logic [3:0] idx);
        in_range = (32'(idx) < REG_COUNT);
    endfunction

    assign w_a_imm = DATA_WIDTH'(r_e.a_imm);
    assign w_a  = r_e.a_from_reg ? (r_a_ok ? r_rda : '0) : w_a_imm;
    assign w_b  = r_e.b_from_reg ? (r_b_ok ? r_rdb : '0) : DATA_WIDTH'(r_e.b_imm);
    assign w_ma = w_a[DATA_WIDTH-1] ? (~w_a + 1'b1) : w_a;
    assign w_mb = w_b[DATA_WIDTH-1] ? (~w_b + 1'b1) : w_b;
    assign w_mv_in = in_range(r_e.a_reg);

    assign w_a_in = in_range(i_q_entry.a_reg);
    assign w_b_in = in_range(i_q_entry.b_reg);

    // restoring divide step, quotient bits shift into r_x
    assign w_rem2 = {r_rem, r_x[DATA_WIDTH-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_y});
    assign w_qd   = {r_x[DATA_WIDTH-2:0], w_ge};

    assign o_q_pop  = (r_st == S_IDLE) && i_q_valid;
    assign w_fin_go = (r_st == S_FIN) && (!r_ov || o_res_if.ready);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_e    <= i_q_entry;
            r_rda  <= r_mem[i_q_entry.a_reg[IW-1:0]];
            r_rdb  <= r_mem[i_q_entry.b_reg[IW-1:0]];
            r_a_ok <= w_a_in && r_vld[i_q_entry.a_reg[IW-1:0]];
            r_b_ok <= w_b_in && r_vld[i_q_entry.b_reg[IW-1:0]];
        end
        if (w_fin_go && r_wr_en) begin
            r_mem[r_wr_idx[IW-1:0]] <= r_res;
        end
        if (w_fin_go) begin
            r_o_acc    <= 32'((r_wr_en && r_wr_idx == 4'd0) ? r_res : r_acc);
            r_o_idx    <= r_wr_en ? r_wr_idx : 4'd0;
            r_o_wrote  <= r_wr_en;
            r_o_taken  <= r_taken;
            r_o_tgt    <= r_taken ? r_target : 32'd0;
            r_o_status <= r_status;
        end

        case (r_st)
            S_EXEC: begin
                r_cnt <= '0;
                r_wr_idx <= 4'd0;
                r_target <= 32'(r_e.a_imm);
                case (r_e.cmd)
                    CMD_ADD: r_res <= w_a + w_b;
                    CMD_SUB: r_res <= w_a - w_b;
                    CMD_MUL: begin
                        r_res <= '0;
                        r_x   <= w_a;
                        r_y   <= w_b;
                    end
                    CMD_DIV: begin
                        r_x   <= w_ma;
                        r_y   <= w_mb;
                        r_rem <= '0;
                        r_neg <= w_a[DATA_WIDTH-1] ^ w_b[DATA_WIDTH-1];
                    end
                    CMD_MOVE: begin
                        r_res    <= w_b;
                        r_wr_idx <= r_e.a_reg;
                    end
                    CMD_CMP: begin
                        if ($signed(w_a) > $signed(w_b)) begin
                            r_res <= DATA_WIDTH'(1);
                        end else if (w_a == w_b) begin
                            r_res <= '0;
                        end else begin
                            r_res <= '1;
                        end
                    end
                    CMD_GCD: begin
                        r_x <= w_a;
                        r_y <= w_b;
                    end
                    CMD_BEQ: r_target <= 32'(r_e.b_imm);
                    default: r_res <= '0;
                endcase
            end
            S_MUL: begin
                if (r_y[0]) begin
                    r_res <= r_res + r_x;
                end
                r_x   <= r_x << 1;
                r_y   <= r_y >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_DIV: begin
                r_rem <= w_ge ? DATA_WIDTH'(w_rem2 - {1'b0, r_y}) : DATA_WIDTH'(w_rem2);
                r_x   <= w_qd;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                    r_res <= r_neg ? (~w_qd + 1'b1) : w_qd;
                end
            end
            S_GCD: begin
                // binary gcd, common factors of two counted in r_cnt
                if (r_x == r_y) begin
                    r_res <= r_x << r_cnt;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x   <= r_x >> 1;
                    r_y   <= r_y >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            default: ;
        endcase

        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_vld    <= '0;
            r_acc    <= '0;
            r_ov     <= 1'b0;
            r_wr_en  <= 1'b0;
            r_taken  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (o_res_if.valid && o_res_if.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_st <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_wr_en  <= 1'b0;
                    r_taken  <= 1'b0;
                    r_status <= r_e.err;
                    r_st     <= S_FIN;
                    if (r_e.err == ST_OK) begin
                        case (r_e.cmd)
                            CMD_ADD, CMD_SUB, CMD_CMP: r_wr_en <= 1'b1;
                            CMD_MUL: begin
                                r_wr_en <= 1'b1;
                                r_st    <= S_MUL;
                            end
                            CMD_DIV: begin
                                if (w_b == '0) begin
                                    r_status <= ST_DIV_ZERO;
                                end else begin
                                    r_wr_en <= 1'b1;
                                    r_st    <= S_DIV;
                                end
                            end
                            CMD_MOVE: r_wr_en <= w_mv_in;
                            CMD_GCD: begin
                                if ($signed(w_a) <= 0 || $signed(w_b) <= 0) begin
                                    r_status <= ST_GCD_ARG;
                                end else begin
                                    r_wr_en <= 1'b1;
                                    r_st    <= S_GCD;
                                end
                            end
                            CMD_JUMP: r_taken <= 1'b1;
                            CMD_BEQ:  r_taken <= (r_acc == w_a_imm);
                            default:  r_status <= ST_BAD_OP;
                        endcase
                    end
                end
                S_MUL, S_DIV: begin
                    if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                        r_st <= S_FIN;
                    end
                end
                S_GCD: begin
                    if (r_x == r_y) begin
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                        if (r_wr_en) begin
                            r_vld[r_wr_idx[IW-1:0]] <= 1'b1;
                            if (r_wr_idx == 4'd0) begin
                                r_acc <= r_res;
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_res_if.valid       = r_ov;
    assign o_res_if.acc_value   = r_o_acc;
    assign o_res_if.written_reg = r_o_idx;
    assign o_res_if.wrote       = r_o_wrote;
    assign o_res_if.jump_taken  = r_o_taken;
    assign o_res_if.jump_target = r_o_tgt;
    assign o_res_if.status      = r_o_status;

endmodule

// ----- rtl/core/toy_isa_execute_unit.sv -----
// top level of the execute unit
// Executes one decoded instruction per transaction against REG_COUNT registers of
// DATA_WIDTH bits and returns one result transaction per instruction, in order. A
// two-entry queue decouples acceptance from execution. add, sub, compare, move,
// jump and branch pass through the back end's idle, execute and finish states;
// multiply and divide run one bit per cycle; gcd uses a binary gcd loop of one
// step per cycle. The register file is
// read once per instruction through registered reads, and the back end holds one
// instruction at a time, so it takes no new one until the last has finished.
module toy_isa_execute_unit
    import tie_pkg::*;
#(
    parameter int REG_COUNT  = 10,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tie_cmd_if.sink   i_cmd_if,
    tie_res_if.source o_res_if
);

    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_q_pop;

    tie_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_if  (i_cmd_if),
        .o_q_valid (w_q_valid),
        .o_q_entry (w_q_entry),
        .i_q_pop   (w_q_pop)
    );

    tie_back #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_q_pop   (w_q_pop),
        .o_res_if  (o_res_if)
    );

endmodule
